// File: rtl/core/pas_pkg.sv
`default_nettype none

package pas_pkg;

    localparam int SYM_W       = 8;
    localparam int PEN_W       = 16;
    localparam int OP_W        = 2;
    localparam int SCORE_W     = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_LEN_DEF = 64;

    // Diagonal cost on a symbol match: -1.0 in Q8.8
    localparam int MATCH_BONUS = -256;
    localparam int SCORE_MAX   = 8388607;
    localparam int SCORE_MIN   = -8388608;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKEW     = 2'd2;

    typedef struct packed {
        logic [PEN_W-1:0] mismatch;
        logic [PEN_W-1:0] gap;
        logic [PEN_W-1:0] skew;
    } pen_t;

    // Control half of a link between neighboring cells; the cost value rides beside it.
    typedef struct packed {
        logic             valid;
        logic             row0;   // border row
        logic             last;   // last row of string a
        logic [SYM_W-1:0] sym;    // symbol of string a for this row
    } link_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/pas_cell.sv
`default_nettype none

// One column of the cost grid: holds one symbol of string b and the column's
// cost from the previous row. Rows of string a stream through left to right.
module pas_cell #(
    parameter int INDEX  = 1,
    parameter int LEN_W  = 7,
    parameter int COST_W = 26
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  pas_pkg::pen_t               pen,
    input  wire  [LEN_W-1:0]            nb,
    input  wire                         b_we,
    input  wire  [LEN_W-1:0]            b_len,
    input  wire  [pas_pkg::SYM_W-1:0]   b_sym,
    input  pas_pkg::link_ctl_t          in_ctl,
    input  wire  signed [COST_W-1:0]    in_val,
    output pas_pkg::link_ctl_t          out_ctl,
    output logic signed [COST_W-1:0]    out_val
);

    localparam logic signed [COST_W-1:0] BONUS = COST_W'(pas_pkg::MATCH_BONUS);

    logic [pas_pkg::SYM_W-1:0] b_sym_reg;
    logic signed [COST_W-1:0]  cost_reg;
    logic signed [COST_W-1:0]  diag_reg;
    pas_pkg::link_ctl_t        out_ctl_reg;
    logic signed [COST_W-1:0]  out_val_reg;

    logic                      active;
    logic signed [COST_W-1:0]  mis_x, gap_x, skew_x, vpen, hpen;
    logic signed [COST_W-1:0]  dn, rt, dg, m1, cell_cost;

    always_comb begin
        mis_x  = signed'({{(COST_W-pas_pkg::PEN_W){1'b0}}, pen.mismatch});
        gap_x  = signed'({{(COST_W-pas_pkg::PEN_W){1'b0}}, pen.gap});
        skew_x = signed'({{(COST_W-pas_pkg::PEN_W){1'b0}}, pen.skew});
        active = (LEN_W'(INDEX) <= nb);
        // last column and last row take the skew penalty
        vpen   = (LEN_W'(INDEX) == nb) ? skew_x : gap_x;
        hpen   = in_ctl.last ? skew_x : gap_x;
        dn     = cost_reg + vpen;
        rt     = in_val + hpen;
        dg     = diag_reg + ((in_ctl.sym == b_sym_reg) ? BONUS : mis_x);
        m1     = (dn < rt) ? dn : rt;
        if (in_ctl.row0) begin
            cell_cost = in_val + skew_x;
        end else begin
            cell_cost = (m1 < dg) ? m1 : dg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_we && (b_len == LEN_W'(INDEX - 1))) begin
            b_sym_reg <= b_sym;
        end
        if (in_ctl.valid) begin
            cost_reg    <= cell_cost;
            diag_reg    <= in_val;
            out_val_reg <= active ? cell_cost : in_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_ctl_reg <= '0;
        end else begin
            out_ctl_reg <= in_ctl;
        end
    end

    assign out_ctl = out_ctl_reg;
    assign out_val = out_val_reg;

endmodule

`default_nettype wire

// File: rtl/core/pas_seq.sv
`default_nettype none

// Load, row issue and result side: string a store, lengths, penalties,
// head of the cell chain and the output register.
module pas_seq #(
    parameter int MAX_LEN = pas_pkg::MAX_LEN_DEF,
    parameter int LEN_W   = 7,
    parameter int ADDR_W  = 6,
    parameter int COST_W  = 26
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [pas_pkg::OP_W-1:0]       in_op,
    input  wire  [pas_pkg::SYM_W-1:0]      in_sym,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [pas_pkg::SCORE_W-1:0]    out_score,
    output logic                           out_ovf,
    input  wire                            cfg_we,
    input  wire  [pas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [pas_pkg::PEN_W-1:0]      cfg_data,
    output pas_pkg::pen_t                  pen,
    output logic [LEN_W-1:0]               nb,
    output logic                           b_we,
    output logic [pas_pkg::SYM_W-1:0]      b_sym,
    output pas_pkg::link_ctl_t             head_ctl,
    output logic signed [COST_W-1:0]       head_val,
    input  pas_pkg::link_ctl_t             tail_ctl,
    input  wire  signed [COST_W-1:0]       tail_val
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    localparam int EXT_W = (COST_W > pas_pkg::SCORE_W) ? COST_W : pas_pkg::SCORE_W + 1;
    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(pas_pkg::SCORE_MAX);
    localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(pas_pkg::SCORE_MIN);

    logic [pas_pkg::SYM_W-1:0] a_mem [MAX_LEN];
    logic [pas_pkg::SYM_W-1:0] a_rd_reg;

    logic [1:0]               state_reg, state_next;
    logic [LEN_W-1:0]         len_a_reg, len_b_reg;
    logic                     ovf_reg;
    logic [LEN_W-1:0]         row_reg;
    logic signed [COST_W-1:0] acc_reg;
    logic signed [COST_W-1:0] hold_reg;
    pas_pkg::pen_t            pen_reg;
    pas_pkg::link_ctl_t       head_ctl_reg;
    logic signed [COST_W-1:0] head_val_reg;
    logic                     m_valid_reg;
    logic [pas_pkg::SCORE_W-1:0] score_reg;
    logic                     m_ovf_reg;

    logic                     accept, a_full, b_full, out_free, tail_hit;
    logic signed [COST_W-1:0] skew_x;
    logic signed [EXT_W-1:0]  hold_ext;
    logic [pas_pkg::SCORE_W-1:0] score_sat;

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        accept   = s_tvalid && s_tready;
        a_full   = (len_a_reg == LEN_W'(MAX_LEN));
        b_full   = (len_b_reg == LEN_W'(MAX_LEN));
        out_free = !m_valid_reg || m_tready;
        tail_hit = tail_ctl.valid && tail_ctl.last;
        skew_x   = signed'({{(COST_W-pas_pkg::PEN_W){1'b0}}, pen_reg.skew});
        b_we     = accept && (in_op == pas_pkg::OP_APPEND_B) && !b_full;
        b_sym    = in_sym;

        hold_ext = EXT_W'(hold_reg);
        if (hold_ext > SAT_HI) begin
            score_sat = pas_pkg::SCORE_W'(SAT_HI);
        end else if (hold_ext < SAT_LO) begin
            score_sat = pas_pkg::SCORE_W'(SAT_LO);
        end else begin
            score_sat = pas_pkg::SCORE_W'(hold_ext);
        end

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (in_op == pas_pkg::OP_COMPUTE)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (row_reg == len_a_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (tail_hit) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // string a store, one registered read port
    always_ff @(posedge aclk) begin
        if (accept && (in_op == pas_pkg::OP_APPEND_A) && !a_full) begin
            a_mem[len_a_reg[ADDR_W-1:0]] <= in_sym;
        end
        a_rd_reg <= a_mem[row_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        head_val_reg <= acc_reg;
        if (state_reg == ST_IDLE) begin
            row_reg <= '0;
            acc_reg <= '0;
        end else if (state_reg == ST_RUN) begin
            row_reg <= row_reg + LEN_W'(1);
            acc_reg <= acc_reg + skew_x;
        end
        if ((state_reg == ST_DRAIN) && tail_hit) begin
            hold_reg <= tail_val;
        end
        if ((state_reg == ST_HOLD) && out_free) begin
            score_reg <= score_sat;
            m_ovf_reg <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_a_reg    <= '0;
            len_b_reg    <= '0;
            ovf_reg      <= 1'b0;
            pen_reg      <= '{mismatch: 16'd256, gap: 16'd256, skew: 16'd256};
            head_ctl_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                unique case (cfg_index)
                    pas_pkg::CFG_MISMATCH: pen_reg.mismatch <= cfg_data;
                    pas_pkg::CFG_GAP:      pen_reg.gap      <= cfg_data;
                    pas_pkg::CFG_SKEW:     pen_reg.skew     <= cfg_data;
                    default: ;
                endcase
            end

            if (accept && (in_op == pas_pkg::OP_APPEND_A)) begin
                if (a_full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    len_a_reg <= len_a_reg + LEN_W'(1);
                end
            end
            if (accept && (in_op == pas_pkg::OP_APPEND_B)) begin
                if (b_full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    len_b_reg <= len_b_reg + LEN_W'(1);
                end
            end

            head_ctl_reg.valid <= (state_reg == ST_RUN);
            head_ctl_reg.row0  <= (row_reg == '0);
            head_ctl_reg.last  <= (row_reg == len_a_reg);
            head_ctl_reg.sym   <= a_rd_reg;

            if ((state_reg == ST_HOLD) && out_free) begin
                m_valid_reg <= 1'b1;
                len_a_reg   <= '0;
                len_b_reg   <= '0;
                ovf_reg     <= 1'b0;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign pen       = pen_reg;
    assign nb        = len_b_reg;
    assign head_ctl  = head_ctl_reg;
    assign head_val  = head_val_reg;
    assign m_tvalid  = m_valid_reg;
    assign out_score = score_reg;
    assign out_ovf   = m_ovf_reg;

endmodule

`default_nettype wire

// File: rtl/core/primer_alignment_score.sv
`default_nettype none

// Global alignment penalty between two symbol strings (Needleman-Wunsch style,
// minimum cost, Q8.8 penalties). Items on s_ either append one symbol to string
// a or b (one item per cycle, no result) or start a compute, which returns one
// item on m_ with the final grid cell, saturated to signed 24 bits, and the flag
// for symbols dropped beyond MAX_LEN; compute then clears both strings. The grid
// is evaluated by a row of MAX_LEN cells, one per column of string b: each cell
// keeps its b symbol and its column cost, and rows of string a walk through the
// row one cell per cycle. Once a compute item is accepted, the rows are issued, the
// last row walks through the head register, the cell row and the hold stage, and
// the result is put on m_. A result still waiting on m_ stalls that last step. No
// further item is accepted during a compute; loads are accepted while a finished
// result waits on m_.
// Configuration: cfg_index 0 mismatch, 1 gap, 2 skew penalty (unsigned Q8.8,
// reset 1.0); write only while idle.
module primer_alignment_score #(
    parameter int MAX_LEN = pas_pkg::MAX_LEN_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [15:0]                        s_tdata,   // [1:0] operation, [9:2] symbol
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [31:0]                        m_tdata,   // [23:0] score, [24] overflowed
    input  wire                                cfg_we,
    input  wire  [pas_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [pas_pkg::PEN_W-1:0]          cfg_data
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    // worst path sum: (2*MAX_LEN + 1) steps of a 16-bit penalty, plus two bits (sign and margin)
    localparam int COST_W = $clog2((2 * MAX_LEN + 1) * 65536) + 2;

    pas_pkg::pen_t               pen;
    logic [LEN_W-1:0]            nb;
    logic                        b_we;
    logic [pas_pkg::SYM_W-1:0]   b_sym;
    logic [pas_pkg::SCORE_W-1:0] out_score;
    logic                        out_ovf;

    // link[k] is the output of cell k; link[0] is the row issue head
    pas_pkg::link_ctl_t          link_ctl [MAX_LEN + 1];
    logic signed [COST_W-1:0]    link_val [MAX_LEN + 1];

    pas_seq #(
        .MAX_LEN (MAX_LEN),
        .LEN_W   (LEN_W),
        .ADDR_W  (ADDR_W),
        .COST_W  (COST_W)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_op     (s_tdata[1:0]),
        .in_sym    (s_tdata[9:2]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_score (out_score),
        .out_ovf   (out_ovf),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pen       (pen),
        .nb        (nb),
        .b_we      (b_we),
        .b_sym     (b_sym),
        .head_ctl  (link_ctl[0]),
        .head_val  (link_val[0]),
        .tail_ctl  (link_ctl[MAX_LEN]),
        .tail_val  (link_val[MAX_LEN])
    );

    // Cells past the length of string b only forward the row they receive,
    // so the last cell always presents the cost of the last used column.
    for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
        pas_cell #(
            .INDEX  (k),
            .LEN_W  (LEN_W),
            .COST_W (COST_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .pen     (pen),
            .nb      (nb),
            .b_we    (b_we),
            .b_len   (nb),
            .b_sym   (b_sym),
            .in_ctl  (link_ctl[k-1]),
            .in_val  (link_val[k-1]),
            .out_ctl (link_ctl[k]),
            .out_val (link_val[k])
        );
    end

    assign m_tdata = {7'b0, out_ovf, out_score};

    // a compute closes the input until its result is out
    a_cmp_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[1:0] == pas_pkg::OP_COMPUTE) |=> !s_tready)
        else $error("input open right after a compute item");

    // rows only travel the cell row during a compute
    a_head_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        link_ctl[0].valid |-> !s_tready)
        else $error("row issued while idle");

    // the final row reaches the chain end only while a compute is pending
    a_tail_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        link_ctl[MAX_LEN].valid && link_ctl[MAX_LEN].last |-> !s_tready)
        else $error("final row at chain end while idle");

endmodule

`default_nettype wire
